// ----- rtl/utf8_glyph_lookup_defines.svh -----
// Assertion macros shared by the glyph lookup RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef UTF8_GLYPH_LOOKUP_DEFINES_SVH
`define UTF8_GLYPH_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UGL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UGL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ugl_pkg.sv -----
// Package for the UTF-8 glyph lookup: types, codes, byte masks, lead decode.
// No dependencies; used by every module of the block.
package ugl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int KEY_W   = 31;
  localparam int COUNT_W = 9;
  localparam int LEN_W   = 3;
  localparam int GLYPH_W = 8;

  // item kinds
  localparam logic CMD_KEY_WRITE = 1'b0;
  localparam logic CMD_BYTE      = 1'b1;

  localparam logic [7:0] BIT7 = 8'b1000_0000;
  localparam logic [7:0] TOP2 = 8'b1100_0000;
  localparam logic [7:0] TOP3 = 8'b1110_0000;
  localparam logic [7:0] TOP4 = 8'b1111_0000;
  localparam logic [7:0] TOP5 = 8'b1111_1000;
  localparam logic [7:0] TOP6 = 8'b1111_1100;
  localparam logic [7:0] TOP7 = 8'b1111_1110;
  localparam logic [7:0] LOW6 = 8'b0011_1111;
  localparam logic [7:0] LOW5 = 8'b0001_1111;
  localparam logic [7:0] LOW4 = 8'b0000_1111;
  localparam logic [7:0] LOW3 = 8'b0000_0111;
  localparam logic [7:0] LOW2 = 8'b0000_0011;
  localparam logic [7:0] LOW1 = 8'b0000_0001;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SEARCH,
    S_EMIT
  } ugl_state_t;

  typedef struct packed {
    logic key_write;
    logic byte_take;
    logic cfg_write;
    logic search_init;
    logic search_step;
  } ugl_cmd_t;

  typedef struct packed {
    logic char_done;
    logic empty;
    logic hit;
    logic exhausted;
  } ugl_status_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       bits;
  } ugl_lead_t;

  // lead byte -> sequence length and payload bits
  function automatic ugl_lead_t lead_decode(input logic [7:0] b);
    ugl_lead_t r;
    if ((b & BIT7) == 8'd0 || (b & TOP2) == BIT7) begin
      r.len = 3'd1; r.bits = b;
    end else if ((b & TOP3) == TOP2) begin
      r.len = 3'd2; r.bits = b & LOW5;
    end else if ((b & TOP4) == TOP3) begin
      r.len = 3'd3; r.bits = b & LOW4;
    end else if ((b & TOP5) == TOP4) begin
      r.len = 3'd4; r.bits = b & LOW3;
    end else if ((b & TOP6) == TOP5) begin
      r.len = 3'd5; r.bits = b & LOW2;
    end else if ((b & TOP7) == TOP6) begin
      r.len = 3'd6; r.bits = b & LOW1;
    end else begin
      r.len = 3'd0; r.bits = 8'd0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/ugl_datapath.sv -----
// Datapath: UTF-8 accumulator, key table memory and binary search registers.
// Depends on ugl_pkg and utf8_glyph_lookup_defines.svh.
`include "utf8_glyph_lookup_defines.svh"

module ugl_datapath #(
  parameter int TABLE_DEPTH = ugl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ugl_pkg::ugl_cmd_t            cmd,
  output ugl_pkg::ugl_status_t         status,
  input  logic [7:0]                   data_byte,
  input  logic [7:0]                   entry_index,
  input  logic [ugl_pkg::KEY_W-1:0]    entry_key,
  input  logic [ugl_pkg::COUNT_W-1:0]  cfg_data,
  output logic [ugl_pkg::KEY_W-1:0]    code_point,
  output logic [ugl_pkg::LEN_W-1:0]    char_bytes,
  output logic                         found,
  output logic [ugl_pkg::GLYPH_W-1:0]  glyph_index
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int BW = $clog2(TABLE_DEPTH + 1);

  logic [ugl_pkg::KEY_W-1:0]   mem [TABLE_DEPTH];
  logic [ugl_pkg::KEY_W-1:0]   rdata;
  logic [IW-1:0]               raddr;

  logic [ugl_pkg::KEY_W-1:0]   acc;
  logic [ugl_pkg::LEN_W-1:0]   remaining;
  logic [ugl_pkg::LEN_W-1:0]   seq_len;
  logic [ugl_pkg::COUNT_W-1:0] table_count;

  logic [BW-1:0] lo, hi, mid;
  logic [BW-1:0] lo_next, hi_next, mid_next, mid_first, n;
  logic [BW:0]   span_sum;
  logic          found_q;
  logic [ugl_pkg::GLYPH_W-1:0] glyph_q;

  ugl_pkg::ugl_lead_t lead;
  logic key_eq, key_lt, in_range;

  assign lead = ugl_pkg::lead_decode(data_byte);

  // clamp the count to the table depth
  always_comb begin
    if (32'(table_count) > 32'(TABLE_DEPTH)) begin
      n = BW'(TABLE_DEPTH);
    end else begin
      n = BW'(table_count);
    end
  end

  assign mid_first = (n - BW'(1)) >> 1;

  assign key_eq = (rdata == acc);
  assign key_lt = (rdata < acc);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (key_lt) begin
      lo_next = mid + BW'(1);
    end else if (!key_eq) begin
      hi_next = mid;
    end
    span_sum = {1'b0, lo_next} + {1'b0, hi_next} - (BW + 1)'(1);
    mid_next = span_sum[BW:1];
  end

  assign raddr    = cmd.search_init ? mid_first[IW-1:0] : mid_next[IW-1:0];
  assign in_range = (32'(entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    status.char_done = (remaining == 3'd1) ||
                       (remaining == 3'd0 && lead.len <= 3'd1);
    status.empty     = (n == '0);
    status.hit       = key_eq;
    status.exhausted = !key_eq && (lo_next >= hi_next);
  end

  // key table
  always_ff @(posedge clk) begin
    if (cmd.key_write && in_range) begin
      mem[IW'(entry_index)] <= entry_key;
    end
    rdata <= mem[raddr];
  end

  // decoder state and count register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      remaining   <= '0;
      seq_len     <= '0;
      table_count <= '0;
    end else begin
      if (cmd.cfg_write) begin
        table_count <= cfg_data;
      end
      if (cmd.byte_take) begin
        if (remaining != 3'd0) begin
          acc       <= {acc[ugl_pkg::KEY_W-7:0], data_byte[5:0]};
          remaining <= remaining - 3'd1;
        end else begin
          acc       <= ugl_pkg::KEY_W'(lead.bits);
          seq_len   <= lead.len;
          remaining <= (lead.len > 3'd1) ? lead.len - 3'd1 : 3'd0;
        end
      end
    end
  end

  // search bounds; hi is exclusive
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo      <= '0;
      hi      <= n;
      mid     <= mid_first;
      found_q <= 1'b0;
      glyph_q <= '0;
    end else if (cmd.search_step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (key_eq) begin
        found_q <= 1'b1;
        glyph_q <= ugl_pkg::GLYPH_W'(mid);
      end
    end
  end

  assign code_point  = acc;
  assign char_bytes  = seq_len;
  assign found       = found_q;
  assign glyph_index = glyph_q;

  `UGL_ASSERT_NEXT(a_cont_count, clk, rst, cmd.byte_take && remaining != 3'd0,
                   remaining == $past(remaining) - 3'd1, "continuation count slip")
  `UGL_ASSERT_NEXT(a_hit_flag, clk, rst, cmd.search_step && key_eq,
                   found_q && glyph_q == ugl_pkg::GLYPH_W'($past(mid)), "hit not latched")

endmodule

// ----- rtl/ugl_ctrl.sv -----
// Controller FSM: item acceptance, search sequencing and result strobe.
// Depends on ugl_pkg and utf8_glyph_lookup_defines.svh.
`include "utf8_glyph_lookup_defines.svh"

module ugl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  input  logic                 cfg_valid,
  input  ugl_pkg::ugl_status_t status,
  output ugl_pkg::ugl_cmd_t    cmd,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 result_valid
);

  ugl_pkg::ugl_state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ugl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    busy            = 1'b1;
    cfg_ready       = 1'b0;
    result_valid    = 1'b0;
    accept          = 1'b0;
    unique case (state)
      ugl_pkg::S_IDLE: begin
        busy          = 1'b0;
        cfg_ready     = 1'b1;
        accept        = start;
        cmd.cfg_write = cfg_valid;
        cmd.key_write = start && command == ugl_pkg::CMD_KEY_WRITE;
        cmd.byte_take = start && command == ugl_pkg::CMD_BYTE;
        if (cmd.byte_take && status.char_done) begin
          state_next = ugl_pkg::S_SETUP;
        end
      end
      ugl_pkg::S_SETUP: begin
        cmd.search_init = 1'b1;
        state_next = status.empty ? ugl_pkg::S_EMIT : ugl_pkg::S_SEARCH;
      end
      ugl_pkg::S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.hit || status.exhausted) begin
          state_next = ugl_pkg::S_EMIT;
        end
      end
      ugl_pkg::S_EMIT: begin
        result_valid = 1'b1;
        state_next   = ugl_pkg::S_IDLE;
      end
      default: begin
        state_next = ugl_pkg::S_IDLE;
      end
    endcase
  end

  `UGL_ASSERT_NEXT(a_emit_once, clk, rst, result_valid, !result_valid && !busy,
                   "result strobe longer than one beat")
  `UGL_ASSERT_NEXT(a_done_search, clk, rst, accept && cmd.byte_take && status.char_done,
                   state == ugl_pkg::S_SETUP, "completed character not searched")
  `UGL_ASSERT_IMPL(a_no_cfg_busy, clk, rst, busy, !cmd.cfg_write && !accept,
                   "write taken while busy")

endmodule

// ----- rtl/utf8_glyph_lookup.sv -----
// Top level of the UTF-8 glyph lookup: controller plus datapath.
// Depends on ugl_pkg, ugl_ctrl and ugl_datapath.
//
// Usage
//  - Items: drive start with command, data_byte, entry_index, entry_key; an
//    item is taken at a rising edge with start high and busy low.
//    command 0 writes entry_key at entry_index (indices past the table depth
//    are dropped); command 1 feeds one UTF-8 byte.
//  - Config: cfg_data carries table_count, written when cfg_valid and
//    cfg_ready are both high; cfg_ready is high whenever the block is idle.
//  - Results: one beat per completed character, shown for one cycle with
//    result_valid high. The receiver cannot stall; it must take the beat.
//  - Flow: key writes and non-final bytes are taken while busy stays low.
//    A final byte passes through accept, setup, the probe loop and the
//    result beat; on an empty table the probe loop is skipped. The probe
//    loop is paced by the key table's single registered read port: one probe
//    per cycle, address of the next probe formed from the current compare.
//  - Reset (rst, synchronous): clears table_count, the decoder state and the
//    FSM. Key table contents are not cleared and are valid once written.
module utf8_glyph_lookup #(
  parameter int TABLE_DEPTH = ugl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [7:0]                   data_byte,
  input  logic [7:0]                   entry_index,
  input  logic [ugl_pkg::KEY_W-1:0]    entry_key,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ugl_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic [ugl_pkg::KEY_W-1:0]    code_point,
  output logic [ugl_pkg::LEN_W-1:0]    char_bytes,
  output logic                         found,
  output logic [ugl_pkg::GLYPH_W-1:0]  glyph_index
);

  ugl_pkg::ugl_cmd_t    cmd;
  ugl_pkg::ugl_status_t status;

  // sequencing: accept, setup, probe loop, result beat
  ugl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .cfg_valid    (cfg_valid),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid)
  );

  // decoder, key memory and search bounds
  ugl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .entry_index (entry_index),
    .entry_key   (entry_key),
    .cfg_data    (cfg_data),
    .code_point  (code_point),
    .char_bytes  (char_bytes),
    .found       (found),
    .glyph_index (glyph_index)
  );

endmodule
